// ===== hw/rtl/pfc_pkg.sv =====
// shared types, format codes and coefficients of the pixel format converter
package pfc_pkg;

  // format codes
  localparam logic [2:0] FMT_GRAY8  = 3'd0;
  localparam logic [2:0] FMT_GRAY16 = 3'd1;
  localparam logic [2:0] FMT_RGB24  = 3'd2;
  localparam logic [2:0] FMT_RGB48  = 3'd3;
  localparam logic [2:0] FMT_RGBA32 = 3'd4;
  localparam logic [2:0] FMT_RGBA64 = 3'd5;
  localparam logic [2:0] FMT_YUV24  = 3'd6;

  // register indexes
  localparam logic REG_SRC_FORMAT = 1'b0;
  localparam logic REG_DST_FORMAT = 1'b1;

  // bit d of entry s set: conversion s to d is supported
  localparam logic [7:0] PAIR_OK [8] = '{8'h7F, 8'h7F, 8'h7F, 8'h7F,
                                         8'h14, 8'h28, 8'h4F, 8'h00};

  // bt.601 yuv to rgb, 16 fraction bits
  localparam int YC_K  = 76284;
  localparam int RV_K  = 104595;
  localparam int GU_K  = 25625;
  localparam int GV_K  = 53281;
  localparam int BU_K  = 132252;

  // upper clamp of a yuv to rgb sum: 255 with 16 fraction bits
  localparam logic [24:0] CLAMP_MAX = 25'd16711680;

  // gray weights, 16 fraction bits
  localparam logic [31:0] GRAY_R_K = 32'd19595;
  localparam logic [31:0] GRAY_G_K = 32'd38470;
  localparam logic [31:0] GRAY_B_K = 32'd7471;

  typedef struct packed {
    logic [2:0] src_format;
    logic [2:0] dst_format;
  } pfc_cfg_t;

  typedef struct packed {
    logic       unsup;
    logic       pass;
    logic       deep;
    logic       src_yuv;
    logic [2:0] dst;
  } pfc_ctl_t;

  typedef struct packed {
    pfc_ctl_t         ctl;
    logic [15:0]      r;
    logic [15:0]      g;
    logic [15:0]      b;
    logic [3:0][15:0] pass_ch;
  } pfc_rgb_t;

  typedef struct packed {
    logic [15:0] out0;
    logic [15:0] out1;
    logic [15:0] out2;
    logic [15:0] out3;
    logic        unsupported;
  } pfc_res_t;

  function automatic logic pair_ok(input logic [2:0] s, input logic [2:0] d);
    logic [7:0] row;
    row = PAIR_OK[s];
    return row[d];
  endfunction

  function automatic logic is_deep(input logic [2:0] f);
    return (f == FMT_GRAY16) || (f == FMT_RGB48) || (f == FMT_RGBA64);
  endfunction

endpackage

// ===== hw/rtl/pfc_stream_if.sv =====
// pixel input and result channels with valid/ready handshake
interface pfc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ch0;
  logic [15:0] ch1;
  logic [15:0] ch2;
  logic [15:0] ch3;

  modport source (output valid, output ch0, output ch1, output ch2, output ch3,
                  input ready);
  modport sink   (input valid, input ch0, input ch1, input ch2, input ch3,
                  output ready);
endinterface

interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out0;
  logic [15:0] out1;
  logic [15:0] out2;
  logic [15:0] out3;
  logic        unsupported;

  modport source (output valid, output out0, output out1, output out2, output out3,
                  output unsupported, input ready);
  modport sink   (input valid, input out0, input out1, input out2, input out3,
                  input unsupported, output ready);
endinterface

// ===== hw/rtl/pfc_apb_regs.sv =====
// apb configuration registers for source and destination format
module pfc_apb_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output pfc_pkg::pfc_cfg_t cfg_o
);
  import pfc_pkg::*;

  logic [2:0] src_q, src_d;
  logic [2:0] dst_q, dst_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    src_d = src_q;
    dst_d = dst_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SRC_FORMAT: src_d = pwdata[2:0];
        REG_DST_FORMAT: dst_d = pwdata[2:0];
        default:        src_d = src_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= FMT_GRAY8;
      dst_q <= FMT_GRAY8;
    end else begin
      src_q <= src_d;
      dst_q <= dst_d;
    end
  end

  assign prdata = (paddr[2] == REG_DST_FORMAT) ? {29'd0, dst_q} : {29'd0, src_q};
  assign cfg_o  = '{src_format: src_q, dst_format: dst_q};

endmodule

// ===== hw/rtl/pfc_yuv2rgb.sv =====
// stages one and two: decode, channel masking, yuv to rgb
module pfc_yuv2rgb (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfc_pkg::pfc_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0][15:0]  ch_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfc_pkg::pfc_rgb_t out_o
);
  import pfc_pkg::*;

  function automatic logic [7:0] clamp_round(input logic signed [27:0] acc);
    logic [24:0] lim;
    logic [24:0] rnd;
    if (acc < 28'sd0) lim = '0;
    else if (acc > $signed({3'b000, CLAMP_MAX})) lim = CLAMP_MAX;
    else lim = acc[24:0];
    rnd = lim + 25'd32768;
    return rnd[23:16];
  endfunction

  // stage one
  logic                     s1_v_q;
  logic                     s1_ready;
  pfc_rgb_t                 s1_q, s1_d;
  logic signed [26:0]       pc_q, pre_q, pgd_q, pge_q, pbd_q;
  logic signed [26:0]       pc_d, pre_d, pgd_d, pge_d, pbd_d;
  // stage two
  logic                     s2_v_q;
  logic                     s2_ready;
  pfc_rgb_t                 s2_q, s2_d;

  logic [2:0]               s, d;
  logic                     deep;
  logic [15:0]              mask;
  logic [2:0]               nch;
  logic signed [9:0]        yc, ud, ve;
  logic signed [27:0]       r_acc, g_acc, b_acc;

  assign s = cfg_i.src_format;
  assign d = cfg_i.dst_format;

  always_comb begin
    deep = is_deep(s);
    mask = deep ? 16'hFFFF : 16'h00FF;
    if (s == FMT_GRAY8 || s == FMT_GRAY16) nch = 3'd1;
    else if (s == FMT_RGBA32 || s == FMT_RGBA64) nch = 3'd4;
    else nch = 3'd3;

    s1_d.ctl.unsup   = !pair_ok(s, d);
    s1_d.ctl.pass    = (s == d);
    s1_d.ctl.deep    = deep;
    s1_d.ctl.src_yuv = (s == FMT_YUV24);
    s1_d.ctl.dst     = d;
    for (int i = 0; i < 4; i++) begin
      s1_d.pass_ch[i] = (3'(i) < nch) ? (ch_i[i] & mask) : 16'd0;
    end
    if (s == FMT_GRAY8 || s == FMT_GRAY16) begin
      s1_d.r = ch_i[0] & mask;
      s1_d.g = ch_i[0] & mask;
      s1_d.b = ch_i[0] & mask;
    end else begin
      s1_d.r = ch_i[0] & mask;
      s1_d.g = ch_i[1] & mask;
      s1_d.b = ch_i[2] & mask;
    end

    yc = $signed({2'b00, ch_i[0][7:0]}) - 10'sd16;
    ud = $signed({2'b00, ch_i[1][7:0]}) - 10'sd128;
    ve = $signed({2'b00, ch_i[2][7:0]}) - 10'sd128;
    pc_d  = 27'(YC_K * yc);
    pre_d = 27'(RV_K * ve);
    pgd_d = 27'(GU_K * ud);
    pge_d = 27'(GV_K * ve);
    pbd_d = 27'(BU_K * ud);
  end

  // stage two: sum, clamp, round
  always_comb begin
    r_acc = 28'(pc_q) + 28'(pre_q);
    g_acc = 28'(pc_q) - 28'(pgd_q) - 28'(pge_q);
    b_acc = 28'(pc_q) + 28'(pbd_q);
    s2_d  = s1_q;
    if (s1_q.ctl.src_yuv) begin
      s2_d.r = {8'd0, clamp_round(r_acc)};
      s2_d.g = {8'd0, clamp_round(g_acc)};
      s2_d.b = {8'd0, clamp_round(b_acc)};
    end
  end

  assign s2_ready   = !s2_v_q || out_ready_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= in_valid_i;
      if (s2_ready) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q  <= s1_d;
      pc_q  <= pc_d;
      pre_q <= pre_d;
      pgd_q <= pgd_d;
      pge_q <= pge_d;
      pbd_q <= pbd_d;
    end
    if (s2_ready && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_o       = s2_q;

endmodule

// ===== hw/rtl/pfc_rgb_out.sv =====
// stages three and four: gray and yuv weighting, output formatting
module pfc_rgb_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pfc_pkg::pfc_rgb_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfc_pkg::pfc_res_t out_o
);
  import pfc_pkg::*;

  // stage three
  logic        s3_v_q;
  logic        s3_ready;
  pfc_rgb_t    s3_q;
  logic [31:0] gr_q, gg_q, gb_q, gr_d, gg_d, gb_d;
  logic [15:0] yr_q, yg_q, yb_q, ur_q, ug_q, ub_q, vr_q, vg_q, vb_q;
  logic [15:0] yr_d, yg_d, yb_d, ur_d, ug_d, ub_d, vr_d, vg_d, vb_d;
  // stage four
  logic        s4_v_q;
  logic        s4_ready;
  pfc_res_t    s4_q, s4_d;

  logic [7:0]  r8, g8, b8;
  logic [32:0] gacc;
  logic [15:0] gray;
  logic [16:0] ysum;
  logic [17:0] usum, vsum;
  logic [7:0]  y8, u8, v8;

  always_comb begin
    r8 = in_i.ctl.deep ? in_i.r[15:8] : in_i.r[7:0];
    g8 = in_i.ctl.deep ? in_i.g[15:8] : in_i.g[7:0];
    b8 = in_i.ctl.deep ? in_i.b[15:8] : in_i.b[7:0];
    gr_d = {16'd0, in_i.r} * GRAY_R_K;
    gg_d = {16'd0, in_i.g} * GRAY_G_K;
    gb_d = {16'd0, in_i.b} * GRAY_B_K;
    yr_d = {8'd0, r8} * 16'd66;
    yg_d = {8'd0, g8} * 16'd129;
    yb_d = {8'd0, b8} * 16'd25;
    ur_d = {8'd0, r8} * 16'd38;
    ug_d = {8'd0, g8} * 16'd74;
    ub_d = {8'd0, b8} * 16'd112;
    vr_d = {8'd0, r8} * 16'd112;
    vg_d = {8'd0, g8} * 16'd94;
    vb_d = {8'd0, b8} * 16'd18;
  end

  always_comb begin
    gacc = 33'(gr_q) + 33'(gg_q) + 33'(gb_q) + 33'd32768;
    gray = gacc[31:16];
    ysum = 17'(yr_q) + 17'(yg_q) + 17'(yb_q);
    y8   = ysum[15:8] + 8'd16;
    // offset keeps the sum positive, so bits 15:8 give floor(x/256)+128
    usum = 18'd32768 + 18'(ub_q) - 18'(ur_q) - 18'(ug_q);
    vsum = 18'd32768 + 18'(vr_q) - 18'(vg_q) - 18'(vb_q);
    u8   = usum[15:8];
    v8   = vsum[15:8];

    s4_d = '0;
    if (s3_q.ctl.unsup) begin
      s4_d.unsupported = 1'b1;
    end else if (s3_q.ctl.pass) begin
      s4_d.out0 = s3_q.pass_ch[0];
      s4_d.out1 = s3_q.pass_ch[1];
      s4_d.out2 = s3_q.pass_ch[2];
      s4_d.out3 = s3_q.pass_ch[3];
    end else begin
      unique case (s3_q.ctl.dst)
        FMT_GRAY8: begin
          s4_d.out0 = s3_q.ctl.deep ? {8'd0, gray[15:8]} : gray;
        end
        FMT_GRAY16: begin
          s4_d.out0 = s3_q.ctl.deep ? gray : {gray[7:0], 8'd0};
        end
        FMT_RGB24, FMT_RGBA32: begin
          s4_d.out0 = s3_q.ctl.deep ? {8'd0, s3_q.r[15:8]} : s3_q.r;
          s4_d.out1 = s3_q.ctl.deep ? {8'd0, s3_q.g[15:8]} : s3_q.g;
          s4_d.out2 = s3_q.ctl.deep ? {8'd0, s3_q.b[15:8]} : s3_q.b;
          s4_d.out3 = (s3_q.ctl.dst == FMT_RGBA32) ? 16'h00FF : 16'h0000;
        end
        FMT_RGB48, FMT_RGBA64: begin
          s4_d.out0 = s3_q.ctl.deep ? s3_q.r : {s3_q.r[7:0], 8'd0};
          s4_d.out1 = s3_q.ctl.deep ? s3_q.g : {s3_q.g[7:0], 8'd0};
          s4_d.out2 = s3_q.ctl.deep ? s3_q.b : {s3_q.b[7:0], 8'd0};
          s4_d.out3 = (s3_q.ctl.dst == FMT_RGBA64) ? 16'hFFFF : 16'h0000;
        end
        FMT_YUV24: begin
          s4_d.out0 = {8'd0, y8};
          s4_d.out1 = {8'd0, u8};
          s4_d.out2 = {8'd0, v8};
        end
        default: s4_d = '0;
      endcase
    end
  end

  assign s4_ready   = !s4_v_q || out_ready_i;
  assign s3_ready   = !s3_v_q || s4_ready;
  assign in_ready_o = s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s3_ready) s3_v_q <= in_valid_i;
      if (s4_ready) s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && in_valid_i) begin
      s3_q <= in_i;
      gr_q <= gr_d;
      gg_q <= gg_d;
      gb_q <= gb_d;
      yr_q <= yr_d;
      yg_q <= yg_d;
      yb_q <= yb_d;
      ur_q <= ur_d;
      ug_q <= ug_d;
      ub_q <= ub_d;
      vr_q <= vr_d;
      vg_q <= vg_d;
      vb_q <= vb_d;
    end
    if (s4_ready && s3_v_q) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = s4_v_q;
  assign out_o       = s4_q;

endmodule

// ===== hw/rtl/pixel_format_converter.sv =====
// top level of the pixel format converter
//
// Converts one pixel per transaction between gray8, gray16, rgb24, rgb48, rgba32,
// rgba64 and yuv24, as chosen by the src_format (address 0) and dst_format
// (address 4) registers; write them only while no pixel is in flight. The block
// accepts one pixel every cycle when the output side is not stalled. The four
// register stages are: decode and yuv to rgb products, yuv sum with clamp and
// rounding, gray and yuv weight products, then the final sums and output
// formatting in the output register. Any stall at the output backs up stage by
// stage, so bubbles are squeezed out and nothing is dropped. An unsupported
// format pair (or code seven) gives zero channels with the unsupported flag set.
module pixel_format_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // pixel channels
  pfc_in_if.sink       pix_i,
  pfc_out_if.source    pix_o
);
  import pfc_pkg::*;

  pfc_cfg_t         cfg;
  logic [3:0][15:0] ch;
  logic             mid_valid;
  logic             mid_ready;
  pfc_rgb_t         mid;
  pfc_res_t         res;

  pfc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // channel order: gray/red/luma, green/u, blue/v, alpha
  assign ch = {pix_i.ch3, pix_i.ch2, pix_i.ch1, pix_i.ch0};

  // front half: masking, pass-through data and yuv to rgb
  pfc_yuv2rgb u_yuv2rgb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .ch_i        (ch),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_o       (mid)
  );

  // back half: gray, rgb to yuv and depth changes
  pfc_rgb_out u_rgb_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_i        (mid),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .out_o       (res)
  );

  assign pix_o.out0        = res.out0;
  assign pix_o.out1        = res.out1;
  assign pix_o.out2        = res.out2;
  assign pix_o.out3        = res.out3;
  assign pix_o.unsupported = res.unsupported;

endmodule

// ===== tb/sv/tb_pixel_format_converter.sv =====
// testbench for the pixel format converter: directed and random pixels checked by a scoreboard
module tb_pixel_format_converter;
  import pfc_pkg::*;

  // code seven is outside the format list and must be flagged
  localparam logic [2:0] FMT_CODE7 = 3'd7;

  // generous bound on the whole run, in clock cycles
  localparam int CYCLE_LIMIT = 400000;
  // four pipeline stages plus margin, waited after the last result
  localparam int PIPE_SETTLE = 8;
  // first mismatches printed in full, the rest only counted
  localparam int REPORT_MAX = 10;

  // result receiver stall patterns
  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  // expected conversion results, one per accepted pixel, in order
  class pixel_scoreboard;
    logic [2:0] src_fmt;
    logic [2:0] dst_fmt;
    pfc_res_t   expected_q[$];
    int         mismatches;

    function new();
      src_fmt    = FMT_GRAY8;
      dst_fmt    = FMT_GRAY8;
      mismatches = 0;
    endfunction

    function void set_format(logic idx, logic [2:0] code);
      if (idx == REG_SRC_FORMAT) src_fmt = code;
      else dst_fmt = code;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit pair_supported();
      case (src_fmt)
        FMT_GRAY8, FMT_GRAY16, FMT_RGB24, FMT_RGB48: return dst_fmt != FMT_CODE7;
        FMT_RGBA32: return dst_fmt inside {FMT_RGB24, FMT_RGBA32};
        FMT_RGBA64: return dst_fmt inside {FMT_RGB48, FMT_RGBA64};
        FMT_YUV24:  return dst_fmt inside {FMT_GRAY8, FMT_GRAY16, FMT_RGB24, FMT_RGB48,
                                           FMT_YUV24};
        default:    return 1'b0;
      endcase
    endfunction

    // clamp to 0..255 in 16.16, round half up, drop the fraction
    function logic [15:0] studio_chan(longint acc);
      if (acc < 0) acc = 0;
      if (acc > 255 * 65536) acc = 255 * 65536;
      return 16'((acc + 32768) >>> 16);
    endfunction

    function pfc_res_t convert(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                               logic [15:0] c3);
      pfc_res_t    res;
      logic        deep;
      logic [15:0] mask;
      int          r, g, b, yy, uu, vv;
      longint      luma_c, chroma_d, chroma_e, gray;
      res = '0;
      if (!pair_supported()) begin
        res.unsupported = 1'b1;
        return res;
      end
      deep = src_fmt inside {FMT_GRAY16, FMT_RGB48, FMT_RGBA64};
      mask = deep ? 16'hFFFF : 16'h00FF;
      // same format: masked pass-through
      if (src_fmt == dst_fmt) begin
        res.out0 = c0 & mask;
        if (!(src_fmt inside {FMT_GRAY8, FMT_GRAY16})) begin
          res.out1 = c1 & mask;
          res.out2 = c2 & mask;
        end
        if (src_fmt inside {FMT_RGBA32, FMT_RGBA64}) res.out3 = c3 & mask;
        return res;
      end
      case (src_fmt)
        FMT_GRAY8, FMT_GRAY16: begin
          r = int'(c0 & mask);
          g = r;
          b = r;
        end
        FMT_YUV24: begin
          luma_c   = longint'(c0[7:0]) - 16;
          chroma_d = longint'(c1[7:0]) - 128;
          chroma_e = longint'(c2[7:0]) - 128;
          r = int'(studio_chan(76284 * luma_c + 104595 * chroma_e));
          g = int'(studio_chan(76284 * luma_c - 25625 * chroma_d - 53281 * chroma_e));
          b = int'(studio_chan(76284 * luma_c + 132252 * chroma_d));
        end
        default: begin
          r = int'(c0 & mask);
          g = int'(c1 & mask);
          b = int'(c2 & mask);
        end
      endcase
      gray = (longint'(r) * 19595 + longint'(g) * 38470 + longint'(b) * 7471 + 32768) >>> 16;
      case (dst_fmt)
        FMT_GRAY8:  res.out0 = 16'(deep ? gray >>> 8 : gray);
        FMT_GRAY16: res.out0 = 16'(deep ? gray : gray <<< 8);
        FMT_RGB24, FMT_RGBA32: begin
          res.out0 = 16'(deep ? r >> 8 : r);
          res.out1 = 16'(deep ? g >> 8 : g);
          res.out2 = 16'(deep ? b >> 8 : b);
          if (dst_fmt == FMT_RGBA32) res.out3 = 16'h00FF;
        end
        FMT_RGB48, FMT_RGBA64: begin
          res.out0 = 16'(deep ? r : r << 8);
          res.out1 = 16'(deep ? g : g << 8);
          res.out2 = 16'(deep ? b : b << 8);
          if (dst_fmt == FMT_RGBA64) res.out3 = 16'hFFFF;
        end
        default: begin
          if (deep) begin
            r = r >> 8;
            g = g >> 8;
            b = b >> 8;
          end
          yy = 66 * r + 129 * g + 25 * b;
          uu = -38 * r - 74 * g + 112 * b;
          vv = 112 * r - 94 * g - 18 * b;
          res.out0 = 16'(((yy >> 8) + 16) & 255);
          res.out1 = 16'(((uu + 32768) >> 8) & 255);
          res.out2 = 16'(((vv + 32768) >> 8) & 255);
        end
      endcase
      return res;
    endfunction

    function void note_pixel(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                             logic [15:0] c3);
      expected_q.push_back(convert(c0, c1, c2, c3));
    endfunction

    function void check_result(pfc_res_t got);
      pfc_res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result %h %h %h %h unsupported %b",
                   got.out0, got.out1, got.out2, got.out3, got.unsupported);
        return;
      end
      want = expected_q.pop_front();
      if (got.out0 !== want.out0 || got.out1 !== want.out1 || got.out2 !== want.out2 ||
          got.out3 !== want.out3 || got.unsupported !== want.unsupported) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"format %0d to %0d: expected %h %h %h %h unsupported %b, ",
                    "got %h %h %h %h unsupported %b"},
                   src_fmt, dst_fmt, want.out0, want.out1, want.out2, want.out3,
                   want.unsupported, got.out0, got.out1, got.out2, got.out3, got.unsupported);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pfc_in_if  pix_in ();
  pfc_out_if pix_out ();

  pixel_scoreboard sb;
  bit              formats_written;
  int              cycles = 0;
  rx_mode_e        rx_mode;
  int              rx_left;

  pixel_format_converter i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_in),
    .pix_o   (pix_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run bound: a hang anywhere ends here as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result receiver: switches to a randomly chosen stall pattern whenever its countdown runs out
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_out.ready <= 1'b0;
      rx_mode       <= RX_STEADY;
      rx_left       <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 160);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_STEADY:  pix_out.ready <= 1'b1;
        RX_RANDOM:  pix_out.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:  pix_out.ready <= ($urandom_range(0, 5) == 0);
        default:    pix_out.ready <= (rx_left[1:0] != 2'd0);
      endcase
    end
  end

  // every result transaction goes to the scoreboard, fields in struct order
  always @(posedge clk) begin
    if (rst_n && pix_out.valid && pix_out.ready)
      sb.check_result({pix_out.out0, pix_out.out1, pix_out.out2, pix_out.out3,
                       pix_out.unsupported});
  end

  // channel values weighted toward the extremes and the 8-bit range
  function automatic logic [15:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      3:       return $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // one pixel transaction; returns at the edge where it was accepted
  task automatic send_pixel(input logic [15:0] c0, input logic [15:0] c1,
                            input logic [15:0] c2, input logic [15:0] c3);
    pix_in.valid <= 1'b1;
    pix_in.ch0   <= c0;
    pix_in.ch1   <= c1;
    pix_in.ch2   <= c2;
    pix_in.ch3   <= c3;
    do @(posedge clk); while (pix_in.ready !== 1'b1);
    sb.note_pixel(c0, c1, c2, c3);
  endtask

  task automatic idle_cycles(input int n);
    pix_in.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold the sender until every pending pixel has come back, then let the pipe settle
  task automatic wait_for_results();
    pix_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // apb write: setup, access until pready, then back to idle
  task automatic write_reg(input logic idx, input logic [2:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {29'd0, code};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_format(idx, code);
    @(posedge clk);
  endtask

  // format registers change only with the pipeline empty
  task automatic apply_formats(input logic [2:0] src, input logic [2:0] dst);
    if (!formats_written || src != sb.src_fmt || dst != sb.dst_fmt) begin
      wait_for_results();
      write_reg(REG_SRC_FORMAT, src);
      write_reg(REG_DST_FORMAT, dst);
      formats_written = 1'b1;
    end
  endtask

  task automatic directed_pixel(input logic [2:0] src, input logic [2:0] dst,
                                input logic [15:0] c0, input logic [15:0] c1,
                                input logic [15:0] c2, input logic [15:0] c3);
    apply_formats(src, dst);
    send_pixel(c0, c1, c2, c3);
  endtask

  initial begin
    logic [5:0] pair_order [64];
    logic [5:0] swap;
    logic [5:0] pair;
    int         j, n, gap, burst_left;
    bit         steady;

    // every block input known from time zero
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    pix_in.valid  <= 1'b0;
    pix_in.ch0    <= '0;
    pix_in.ch1    <= '0;
    pix_in.ch2    <= '0;
    pix_in.ch3    <= '0;
    formats_written = 1'b0;
    burst_left    = 0;
    sb = new();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through masks, including alpha
    directed_pixel(FMT_GRAY8,  FMT_GRAY8,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    directed_pixel(FMT_GRAY16, FMT_GRAY16, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'hFFFF);
    directed_pixel(FMT_RGBA64, FMT_RGBA64, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234);
    directed_pixel(FMT_RGBA32, FMT_RGBA32, 16'h01FF, 16'h02FE, 16'h03FD, 16'h04FC);
    directed_pixel(FMT_YUV24,  FMT_YUV24,  16'hABCD, 16'h5555, 16'hAAAA, 16'hFFFF);
    // gray of equal channels returns the channel, at both depths
    directed_pixel(FMT_RGB24,  FMT_GRAY8,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    directed_pixel(FMT_RGB48,  FMT_GRAY8,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    directed_pixel(FMT_RGB48,  FMT_GRAY16, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    // depth changes and alpha fill
    directed_pixel(FMT_GRAY8,  FMT_GRAY16, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    directed_pixel(FMT_GRAY16, FMT_RGBA32, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    directed_pixel(FMT_RGB24,  FMT_RGBA64, 16'h0080, 16'h007F, 16'h0001, 16'hAAAA);
    // yuv to rgb: clamp at the bottom and the top, black, white, a saturated color
    directed_pixel(FMT_YUV24,  FMT_RGB24,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    directed_pixel(FMT_YUV24,  FMT_RGB24,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    directed_pixel(FMT_YUV24,  FMT_RGB48,  16'h0010, 16'h0080, 16'h0080, 16'h0000);
    directed_pixel(FMT_YUV24,  FMT_GRAY8,  16'h00EB, 16'h0080, 16'h0080, 16'h0000);
    directed_pixel(FMT_YUV24,  FMT_GRAY16, 16'h0051, 16'h005A, 16'h00F0, 16'h0000);
    // rgb to yuv with negative chroma sums that floor downward
    directed_pixel(FMT_RGB24,  FMT_YUV24,  16'h0000, 16'h0000, 16'h00FF, 16'h0000);
    directed_pixel(FMT_RGB24,  FMT_YUV24,  16'h00FF, 16'h0000, 16'h0000, 16'h0000);
    directed_pixel(FMT_RGB24,  FMT_YUV24,  16'h0000, 16'h00FF, 16'h0000, 16'h0000);
    // 16-bit sources cut to 8 bits before yuv
    directed_pixel(FMT_RGB48,  FMT_YUV24,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    directed_pixel(FMT_GRAY16, FMT_YUV24,  16'h8000, 16'h0000, 16'h0000, 16'h0000);
    // unsupported pairs and code seven on either side
    directed_pixel(FMT_RGBA32, FMT_GRAY8,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    directed_pixel(FMT_RGBA64, FMT_RGB24,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    directed_pixel(FMT_YUV24,  FMT_RGBA32, 16'h0080, 16'h0080, 16'h0080, 16'h0080);
    directed_pixel(FMT_CODE7,  FMT_GRAY8,  16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF);
    directed_pixel(FMT_GRAY8,  FMT_CODE7,  16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF);

    // all 64 register pairs in shuffled order, then a few repeats
    for (int i = 0; i < 64; i++) pair_order[i] = 6'(i);
    for (int i = 63; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap          = pair_order[i];
      pair_order[i] = pair_order[j];
      pair_order[j] = swap;
    end

    for (int p = 0; p < 70; p++) begin
      pair = (p < 64) ? pair_order[p] : 6'($urandom_range(0, 63));
      apply_formats(pair[5:3], pair[2:0]);
      n      = $urandom_range(16, 32);
      // some phases stream back to back with no sender gaps
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        if (!steady) begin
          if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) idle_cycles(gap);
            burst_left = $urandom_range(1, 24);
          end
          burst_left--;
        end
        send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel());
      end
    end

    wait_for_results();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_stream_if.sv
hw/rtl/pfc_apb_regs.sv
hw/rtl/pfc_yuv2rgb.sv
hw/rtl/pfc_rgb_out.sv
hw/rtl/pixel_format_converter.sv
tb/sv/tb_pixel_format_converter.sv
